>>> hdl/lkc_pkg.sv
// Shared types and constants for the LRU keyed entry cache.
// Used by the top level; has no dependencies of its own.
package lkc_pkg;

  localparam int ENTRIES = 128;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [31:0] STAMP_LIMIT = 32'd10000000;
  localparam logic [31:0] STAMP_START = 32'd1;
  localparam logic [31:0] STAMP_MAX   = 32'h7FFF_FFFF;
  localparam logic [7:0]  CAP_RESET   = 8'd128;

  localparam int OCC_W = 8;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;

  // APB register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    MODE_FETCH  = 2'd0,
    MODE_TOUCH  = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_REBASE,
    ST_INSERT,
    ST_DONE
  } state_e;

endpackage

>>> hdl/lru_keyed_entry_cache.sv
// Top level of the LRU keyed entry cache: sequencer, scan unit, valid bits.
// Depends on lkc_pkg and lkc_ram (key store and age stamp store).
//
//  channel  | direction | signals                    | contents
//  ---------+-----------+----------------------------+---------------------------------
//  s_axis   | in        | tvalid/tready/tdata/tuser  | request: key, mode, key_known
//  m_axis   | out       | tvalid/tready/tdata        | result: flags, evicted key, occ.
//  apb      | in/out    | psel/penable/pwrite/paddr  | capacity register at address 0
//
// One request at a time. Each takes a pass over all 128 slots through the one-read-port
// stores, and a fetch of a known key that misses also takes an insert step. An insert
// into a full store whose stamp counter has reached the limit adds a rebase pass over every
// stamp. The store starts empty after reset, with no clearing pass.
// A stalled result sits in the output register while the next request is scanned; that
// request then holds in the done state until the register is taken.
module lru_keyed_entry_cache
  import lkc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] entry_key
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode, [2] key_known
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] hit, [1] inserted, [2] evicted, [34:3] evicted_key, [42:35] occupancy,
  // [47:43] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  state_e state_q, state_d;

  mode_e              req_mode_q;
  logic [31:0]        req_key_q;
  logic               req_known_q;

  logic [CNT_W-1:0]   cnt_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;

  logic               found_q;
  logic [IDX_W-1:0]   slot_q;
  logic               old_found_q;
  logic [IDX_W-1:0]   old_idx_q;
  logic signed [31:0] old_stamp_q;
  logic [31:0]        old_key_q;
  logic               free_found_q;
  logic [IDX_W-1:0]   free_idx_q;

  logic               ins_ok_q;
  logic [IDX_W-1:0]   ins_idx_q;
  logic               res_ins_q;
  logic               res_ev_q;
  logic [31:0]        res_evkey_q;

  logic [ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]   count_q;
  logic [31:0]        stamp_q;
  logic [7:0]         cap_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // store ports
  logic [31:0]      key_rdata, age_rdata;
  logic             key_we, age_we;
  logic [IDX_W-1:0] ram_raddr, key_waddr, age_waddr;
  logic [31:0]      key_wdata, age_wdata;

  logic             in_xfer, out_free, cfg_wr;
  logic             scan_done;
  logic [31:0]      stamp_next;
  logic [CNT_W-1:0] eff_cap;
  logic             rd_entry_vld;

  // decide-step flags
  logic             dec_restamp, dec_remove, dec_insert, dec_full, dec_evict, dec_rebase;
  logic             dec_ins_ok;
  logic [IDX_W-1:0] dec_ins_idx;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign scan_done = (cnt_q == CNT_W'(ENTRIES)) && !rd_vld_q;
  assign stamp_next = (stamp_q < STAMP_MAX) ? stamp_q + 32'd1 : stamp_q;
  assign rd_entry_vld = valid_q[rd_idx_q];

  always_comb begin
    if (cap_q == 8'd0) begin
      eff_cap = CNT_W'(1);
    end else if (CNT_W'(cap_q) > CNT_W'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  always_comb begin
    dec_restamp = found_q && (req_mode_q == MODE_FETCH || req_mode_q == MODE_TOUCH);
    dec_remove  = found_q && (req_mode_q == MODE_REMOVE);
    dec_insert  = !found_q && (req_mode_q == MODE_FETCH) && req_known_q;
    dec_full    = count_q >= eff_cap;
    dec_evict   = dec_insert && dec_full && old_found_q;
    dec_rebase  = dec_insert && dec_full && (stamp_q >= STAMP_LIMIT);
    // lowest free slot after the eviction
    if (dec_evict) begin
      dec_ins_ok  = 1'b1;
      dec_ins_idx = (free_found_q && (free_idx_q < old_idx_q)) ? free_idx_q : old_idx_q;
    end else begin
      dec_ins_ok  = free_found_q;
      dec_ins_idx = free_idx_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE: begin
        priority if (dec_rebase) state_d = ST_REBASE;
        else if (dec_insert) state_d = ST_INSERT;
        else state_d = ST_DONE;
      end
      ST_REBASE: if (scan_done) state_d = ST_INSERT;
      ST_INSERT: state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // store controls and handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_raddr = cnt_q[IDX_W-1:0];
    key_we    = 1'b0;
    key_waddr = ins_idx_q;
    key_wdata = req_key_q;
    age_we    = 1'b0;
    age_waddr = ins_idx_q;
    age_wdata = stamp_q;
    unique case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_DECIDE: begin
        age_we    = dec_restamp;
        age_waddr = slot_q;
      end
      ST_REBASE: begin
        age_we    = rd_vld_q && rd_entry_vld;
        age_waddr = rd_idx_q;
        age_wdata = age_rdata - STAMP_LIMIT;
      end
      ST_INSERT: begin
        key_we = ins_ok_q;
        age_we = ins_ok_q;
      end
      default: ;
    endcase
  end

  lkc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (key_rdata)
  );

  lkc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (age_waddr),
    .wdata_i (age_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (age_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      req_mode_q   <= MODE_NOP;
      req_key_q    <= '0;
      req_known_q  <= 1'b0;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      found_q      <= 1'b0;
      slot_q       <= '0;
      old_found_q  <= 1'b0;
      old_idx_q    <= '0;
      old_stamp_q  <= '0;
      old_key_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      ins_ok_q     <= 1'b0;
      ins_idx_q    <= '0;
      res_ins_q    <= 1'b0;
      res_ev_q     <= 1'b0;
      res_evkey_q  <= '0;
      valid_q      <= '0;
      count_q      <= '0;
      stamp_q      <= STAMP_START;
      cap_q        <= CAP_RESET;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        cap_q <= pwdata[7:0];
      end
      // load the result when the register is free, else drop it once taken
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {5'd0, OCC_W'(count_q), res_evkey_q, res_ev_q, res_ins_q, found_q};
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            req_mode_q   <= mode_e'(s_axis_tuser[1:0]);
            req_known_q  <= s_axis_tuser[2];
            req_key_q    <= s_axis_tdata;
            cnt_q        <= '0;
            rd_vld_q     <= 1'b0;
            found_q      <= 1'b0;
            old_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            ins_ok_q     <= 1'b0;
            res_ins_q    <= 1'b0;
            res_ev_q     <= 1'b0;
            res_evkey_q  <= '0;
          end
        end
        ST_SCAN, ST_REBASE: begin
          // issue one read a cycle; the registered data comes back in the next cycle
          rd_vld_q <= (cnt_q != CNT_W'(ENTRIES));
          rd_idx_q <= cnt_q[IDX_W-1:0];
          if (cnt_q != CNT_W'(ENTRIES)) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (state_q == ST_SCAN && rd_vld_q) begin
            if (rd_entry_vld && !found_q && key_rdata == req_key_q) begin
              found_q <= 1'b1;
              slot_q  <= rd_idx_q;
            end
            // strict compare keeps the lowest slot on a tie
            if (rd_entry_vld && (!old_found_q || $signed(age_rdata) < old_stamp_q)) begin
              old_found_q <= 1'b1;
              old_idx_q   <= rd_idx_q;
              old_stamp_q <= $signed(age_rdata);
              old_key_q   <= key_rdata;
            end
            if (!rd_entry_vld && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= rd_idx_q;
            end
          end
        end
        ST_DECIDE: begin
          cnt_q     <= '0;
          rd_vld_q  <= 1'b0;
          ins_ok_q  <= dec_ins_ok;
          ins_idx_q <= dec_ins_idx;
          if (dec_restamp) begin
            stamp_q <= stamp_next;
          end
          if (dec_remove) begin
            valid_q[slot_q] <= 1'b0;
            count_q         <= count_q - CNT_W'(1);
          end
          if (dec_evict) begin
            valid_q[old_idx_q] <= 1'b0;
            count_q            <= count_q - CNT_W'(1);
            res_ev_q           <= 1'b1;
            res_evkey_q        <= old_key_q;
          end
          if (dec_rebase) begin
            stamp_q <= stamp_q - STAMP_LIMIT;
          end
        end
        ST_INSERT: begin
          if (ins_ok_q) begin
            valid_q[ins_idx_q] <= 1'b1;
            count_q            <= count_q + CNT_W'(1);
            stamp_q            <= stamp_next;
            res_ins_q          <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_CAPACITY) ? {24'd0, cap_q} : 32'd0;

`ifndef ASSERT_OFF
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'($countones(valid_q)) == count_q)
    else $error("entry count differs from number of valid slots");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES))
    else $error("entry count above store depth");

  a_hit_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("result reports both hit and insert");

  a_evict_then_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("eviction without insert");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_xfer)
    else $error("request accepted while busy");
`endif

endmodule

>>> hdl/lkc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
module lkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> dv/lkc_tb_pkg.sv
`timescale 1ns / 1ps
// Request and outcome types plus the residency tracker that predicts and checks results.
// Depends on lkc_pkg for the mode encoding, store size and stamp constants.
package lkc_tb_pkg;
  import lkc_pkg::*;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] key;
    logic        known;
  } request_t;

  // Laid out as on m_axis_tdata: hit in bit 0 up to occupancy in [42:35]
  typedef struct packed {
    logic [7:0]  occupancy;
    logic [31:0] evicted_key;
    logic        evicted;
    logic        inserted;
    logic        hit;
  } outcome_t;

  class residency_tracker;
    logic [31:0] slot_key   [ENTRIES];
    bit          slot_valid [ENTRIES];
    logic [31:0] slot_stamp [ENTRIES];
    logic [31:0] stamp_ctr;
    int unsigned occupancy;
    logic [7:0]  capacity;
    outcome_t    pending_outcomes[$];
    int unsigned failures;
    int unsigned checked;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_stamp[i] = '0;
      end
      stamp_ctr = STAMP_START;
      occupancy = 0;
      capacity  = CAP_RESET;
      failures  = 0;
      checked   = 0;
    endfunction

    function void set_capacity(logic [7:0] value);
      capacity = value;
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) begin
        $display("ERROR: %s", what);
      end
    endfunction

    // Hand out the current stamp; saturate at the largest positive value
    function logic [31:0] take_stamp();
      logic [31:0] s;
      s = stamp_ctr;
      if (stamp_ctr < STAMP_MAX) begin
        stamp_ctr = stamp_ctr + 1;
      end
      return s;
    endfunction

    function outcome_t predict_outcome(request_t r);
      outcome_t res;
      int slot;
      int oldest;
      int cap_eff;
      bit placed;
      res    = '0;
      slot   = -1;
      oldest = -1;
      placed = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && slot_valid[i] && slot_key[i] == r.key) begin
          slot = i;
        end
      end
      res.hit = (slot >= 0);
      case (r.mode)
        MODE_FETCH: begin
          if (slot >= 0) begin
            slot_stamp[slot] = take_stamp();
          end else if (r.known) begin
            cap_eff = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
            if (occupancy >= cap_eff) begin
              // Oldest stamp goes, signed compare, lowest slot wins a tie
              for (int i = 0; i < ENTRIES; i++) begin
                if (slot_valid[i]) begin
                  if (oldest < 0) begin
                    oldest = i;
                  end else if ($signed(slot_stamp[i]) < $signed(slot_stamp[oldest])) begin
                    oldest = i;
                  end
                end
              end
              if (oldest >= 0) begin
                slot_valid[oldest] = 1'b0;
                res.evicted     = 1'b1;
                res.evicted_key = slot_key[oldest];
                if (occupancy > 0) begin
                  occupancy--;
                end
              end
              if (stamp_ctr >= STAMP_LIMIT) begin
                stamp_ctr = stamp_ctr - STAMP_LIMIT;
                for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_valid[i]) begin
                    slot_stamp[i] = slot_stamp[i] - STAMP_LIMIT;
                  end
                end
              end
            end
            for (int i = 0; i < ENTRIES; i++) begin
              if (!placed && !slot_valid[i]) begin
                slot_valid[i] = 1'b1;
                slot_key[i]   = r.key;
                slot_stamp[i] = take_stamp();
                occupancy++;
                res.inserted = 1'b1;
                placed = 1'b1;
              end
            end
          end
        end
        MODE_TOUCH: begin
          if (slot >= 0) begin
            slot_stamp[slot] = take_stamp();
          end
        end
        MODE_REMOVE: begin
          if (slot >= 0) begin
            slot_valid[slot] = 1'b0;
            if (occupancy > 0) begin
              occupancy--;
            end
          end
        end
        default: begin
        end
      endcase
      res.occupancy = occupancy[7:0];
      return res;
    endfunction

    function void note_request(request_t r);
      pending_outcomes.push_back(predict_outcome(r));
    endfunction

    function void check_result(outcome_t got);
      outcome_t exp;
      checked++;
      if (pending_outcomes.size() == 0) begin
        flag($sformatf("outcome %0d arrived with none pending: hit=%0b ins=%0b ev=%0b key=%h occ=%0d",
                       checked, got.hit, got.inserted, got.evicted, got.evicted_key,
                       got.occupancy));
        return;
      end
      exp = pending_outcomes.pop_front();
      if (exp.hit != got.hit || exp.inserted != got.inserted || exp.evicted != got.evicted ||
          exp.evicted_key != got.evicted_key || exp.occupancy != got.occupancy) begin
        flag($sformatf({"outcome %0d: exp hit=%0b ins=%0b ev=%0b key=%h occ=%0d, ",
                        "got hit=%0b ins=%0b ev=%0b key=%h occ=%0d"},
                       checked, exp.hit, exp.inserted, exp.evicted, exp.evicted_key,
                       exp.occupancy, got.hit, got.inserted, got.evicted, got.evicted_key,
                       got.occupancy));
      end
    endfunction
  endclass

endpackage

>>> dv/lru_keyed_entry_cache_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_keyed_entry_cache: directed and pooled-key random requests
// over a series of capacity settings. Depends on lkc_pkg, lkc_tb_pkg and the RTL.
module lru_keyed_entry_cache_tb;
  import lkc_pkg::*;
  import lkc_tb_pkg::*;

  localparam int RUN_LIMIT = 4000000;
  localparam int HOLD_OFF_CYCLES = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [31:0] entry_key
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // [1:0] mode, [2] key_known
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] hit, [1] inserted, [2] evicted, [34:3] evicted_key, [42:35] occupancy
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  residency_tracker tracker;
  logic [31:0] key_pool [256];
  int unsigned requests_sent = 0;
  int unsigned cycle_count = 0;
  logic        no_gaps = 1'b0;
  logic        hold_off = 1'b0;

  lru_keyed_entry_cache i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count == RUN_LIMIT);
    $display("lru_keyed_entry_cache: mismatch");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 94) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 80);
  endfunction

  task automatic send_request(input mode_e mode, input logic [31:0] key, input logic known);
    request_t r;
    int gap;
    r.mode  = mode;
    r.key   = key;
    r.known = known;
    gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.key;
    s_axis_tuser  <= {r.known, r.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(r);
    requests_sent++;
  endtask

  task automatic wait_drained();
    while (tracker.pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Write the capacity register, then read it back
  task automatic set_capacity_reg(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_capacity(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] != value) begin
      tracker.flag($sformatf("capacity readback %0d, wrote %0d", prdata[7:0], value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] cap, input int count);
    int pool_n;
    int r;
    mode_e mode;
    logic [31:0] key;
    set_capacity_reg(cap);
    pool_n = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
    pool_n = pool_n * 3 / 2 + 2;
    if (pool_n > 256) begin
      pool_n = 256;
    end
    no_gaps <= ($urandom_range(0, 3) == 0);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        mode = MODE_FETCH;
      end else if (r < 78) begin
        mode = MODE_TOUCH;
      end else if (r < 93) begin
        mode = MODE_REMOVE;
      end else begin
        mode = MODE_NOP;
      end
      // Mostly pooled keys so hits and evictions happen, a few fresh ones
      key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, pool_n - 1)];
      send_request(mode, key, $urandom_range(0, 99) < 85);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin : result_sink
    int stall_left;
    outcome_t got;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = outcome_t'(m_axis_tdata[$bits(outcome_t)-1:0]);
        tracker.check_result(got);
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Starve the output long enough that the block backs up into its input
  initial begin : output_hold_off
    wait (requests_sent >= 700);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    tracker = new();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 256; i++) begin
      key_pool[i] = $urandom();
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Misses, hits, touch and remove of absent keys, unused mode, at reset capacity
    send_request(MODE_FETCH, 32'h0000_0000, 1'b0);
    send_request(MODE_FETCH, 32'h0000_0000, 1'b1);
    send_request(MODE_FETCH, 32'h0000_0000, 1'b1);
    send_request(MODE_TOUCH, 32'hFFFF_FFFF, 1'b1);
    send_request(MODE_FETCH, 32'hFFFF_FFFF, 1'b0);
    send_request(MODE_FETCH, 32'hFFFF_FFFF, 1'b1);
    send_request(MODE_TOUCH, 32'hFFFF_FFFF, 1'b0);
    send_request(MODE_NOP, 32'hFFFF_FFFF, 1'b1);
    send_request(MODE_NOP, 32'h5A5A_5A5A, 1'b0);
    send_request(MODE_REMOVE, 32'h0000_0000, 1'b1);
    send_request(MODE_REMOVE, 32'h0000_0000, 1'b1);
    send_request(MODE_TOUCH, 32'h0000_0000, 1'b1);
    send_request(MODE_FETCH, 32'hA5A5_A5A5, 1'b1);
    send_request(MODE_FETCH, 32'h5A5A_5A5A, 1'b1);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Capacity below occupancy: each full insert evicts just one
    set_capacity_reg(8'd2);
    send_request(MODE_FETCH, 32'h1234_5678, 1'b1);
    send_request(MODE_TOUCH, 32'hA5A5_A5A5, 1'b1);
    send_request(MODE_FETCH, 32'h0000_0000, 1'b1);
    send_request(MODE_REMOVE, 32'h1234_5678, 1'b0);
    send_request(MODE_REMOVE, 32'hA5A5_A5A5, 1'b1);
    send_request(MODE_FETCH, 32'h5A5A_5A5A, 1'b1);
    send_request(MODE_FETCH, 32'hFFFF_FFFF, 1'b1);
    send_request(MODE_FETCH, 32'hFFFF_FFFF, 1'b1);
    send_request(MODE_NOP, 32'h0000_0000, 1'b1);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    run_phase(8'd4, 200);
    run_phase(8'd1, 120);
    run_phase(8'd0, 100);
    run_phase(8'd16, 200);
    run_phase(8'd3, 150);
    run_phase(8'd255, 400);
    run_phase(8'd128, 300);
    run_phase(8'd200, 100);
    run_phase(8'd32, 330);

    repeat (300) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending_outcomes.size() == 0) begin
      $display("lru_keyed_entry_cache: match");
    end else begin
      $display("lru_keyed_entry_cache: mismatch");
    end
    $finish;
  end

endmodule

>>> lru_keyed_entry_cache.f
hdl/lkc_pkg.sv
hdl/lkc_ram.sv
hdl/lru_keyed_entry_cache.sv
dv/lkc_tb_pkg.sv
dv/lru_keyed_entry_cache_tb.sv
